// File: rtl/swm_pkg.sv
// shared constants, datapath command codes and control structs for the
// sliding window median filter; no dependencies
package swm_pkg;

    // default capacity and sample width
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // width of the window_size register
    localparam int CFG_W = 7;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_OLD,
        OP_FIND_RD,
        OP_FIND_CMP,
        OP_SHIFT_RD,
        OP_SHIFT_CMP,
        OP_FINAL,
        OP_MED_RD,
        OP_MED_OUT
    } op_t;

    // controller to datapath
    typedef struct packed {
        op_t  op;
        logic med_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic fill_zero;
        logic hit;
        logic move;
        logic at_end;
    } status_t;

endpackage

// File: rtl/swm_in_if.sv
// input channel of the median filter: one sample word per handshake
// depends on swm_pkg for the default sample width
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

// File: rtl/swm_out_if.sv
// output channel of the median filter: one median word per handshake
// depends on swm_pkg for the default sample width
interface swm_out_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

// File: rtl/sliding_window_median.sv
// Sliding window median filter. Each input word carries a signed sample and a
// start flag; the start flag empties the window before its sample is taken.
// Once window_size samples are held, every further sample displaces the
// oldest and one output word with the lower median (rank ceil(k/2)-1) follows;
// the first window_size-1 samples of a stream give no output. Writing
// window_size (zero reads as one, values above the capacity saturate) also
// restarts the stream. Samples are processed one at a time: a sorted copy of
// the window lives in a RAM with one read and one write port, and each
// element the update examines takes a registered read, then a compare and
// write. Before the window fills, the new sample moves down past the larger
// samples held; with a full window the update first finds the displaced
// sample, then moves the new one past the samples it passes, up to either
// end of the window. An item with a result also waits while the output
// register still holds an unread word. The result sits in an output
// register, so a stalled consumer only holds up the next result, not the
// next input word.
//
// depends on swm_pkg, swm_in_if, swm_out_if, swm_ctrl, swm_datapath, swm_ram
module sliding_window_median #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    swm_in_if.sink                    in_ch,
    swm_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] cfg_wdata
);
    swm_pkg::cmd_t    cmd;
    swm_pkg::status_t status;

    logic signed [SAMPLE_WIDTH-1:0] median;

    assign out_ch.median = median;

    // sequencer
    swm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and compare logic
    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_sample (in_ch.sample),
        .in_start  (in_ch.start_req),
        .cmd       (cmd),
        .status    (status),
        .median    (median)
    );
endmodule

// File: rtl/swm_ram.sv
// generic simple dual port RAM, one write and one registered read per cycle
// no dependencies; read during write to the same address returns old data
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]              wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/swm_ctrl.sv
// controller of the median filter: sequences load, ring update, search,
// shift and median read; depends on swm_pkg for command and status structs
module swm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  swm_pkg::status_t status,
    output swm_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_OLD,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_CMP,
        ST_FINAL,
        ST_MED_RD,
        ST_MED_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = swm_pkg::OP_NONE;
        cmd.med_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = swm_pkg::OP_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.op = swm_pkg::OP_PREP;
                if (status.full)
                    state_next = ST_OLD;
                else if (status.fill_zero)
                    state_next = ST_FINAL;
                else
                    state_next = ST_SHIFT_RD;
            end
            ST_OLD:
            begin
                cmd.op     = swm_pkg::OP_OLD;
                state_next = ST_FIND_RD;
            end
            ST_FIND_RD:
            begin
                cmd.op     = swm_pkg::OP_FIND_RD;
                state_next = ST_FIND_CMP;
            end
            ST_FIND_CMP:
            begin
                cmd.op = swm_pkg::OP_FIND_CMP;
                if (!status.hit)
                    state_next = ST_FIND_RD;
                else if (status.at_end)
                    state_next = ST_FINAL;
                else
                    state_next = ST_SHIFT_RD;
            end
            ST_SHIFT_RD:
            begin
                cmd.op     = swm_pkg::OP_SHIFT_RD;
                state_next = ST_SHIFT_CMP;
            end
            ST_SHIFT_CMP:
            begin
                cmd.op = swm_pkg::OP_SHIFT_CMP;
                if (!status.move)
                    state_next = ST_MED_RD;
                else if (status.at_end)
                    state_next = ST_FINAL;
                else
                    state_next = ST_SHIFT_RD;
            end
            ST_FINAL:
            begin
                cmd.op     = swm_pkg::OP_FINAL;
                state_next = ST_MED_RD;
            end
            ST_MED_RD:
            begin
                cmd.op     = swm_pkg::OP_MED_RD;
                state_next = status.full ? ST_MED_OUT : ST_IDLE;
            end
            ST_MED_OUT:
            begin
                cmd.op = swm_pkg::OP_MED_OUT;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.med_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb
    begin
        if (cmd.med_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: rtl/swm_datapath.sv
// datapath of the median filter: arrival-order ring, sorted store, counters
// and compare logic; depends on swm_pkg and swm_ram
module swm_datapath #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    input  logic                           in_start,
    input  swm_pkg::cmd_t                  cmd,
    output swm_pkg::status_t               status,
    output logic signed [SAMPLE_WIDTH-1:0] median
);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] hole_reg;
    logic [IDX_W-1:0] j_reg;
    logic             dir_up_reg;

    logic signed [SAMPLE_WIDTH-1:0] s_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;

    logic [SAMPLE_WIDTH-1:0]        ring_rdata;
    logic [SAMPLE_WIDTH-1:0]        sort_rdata;
    logic signed [SAMPLE_WIDTH-1:0] ring_rd;
    logic signed [SAMPLE_WIDTH-1:0] sort_rd;

    logic [CNT_W-1:0] k_cfg;
    logic             full;
    logic             j_last;
    logic             j_zero;
    logic             at_end;
    logic             hit;
    logic             move;
    logic [CNT_W:0]   pos_plus;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] j_step;
    logic [IDX_W-1:0] rank;

    logic             ring_we;
    logic [IDX_W-1:0] ring_waddr;
    logic             sort_we;
    logic [IDX_W-1:0] sort_raddr;
    logic [SAMPLE_WIDTH-1:0] sort_wdata;

    assign ring_rd = ring_rdata;
    assign sort_rd = sort_rdata;
    assign median  = median_reg;

    // window size from a register write: zero means one, saturate at capacity
    always_comb
    begin
        if (cfg_wdata == '0)
            k_cfg = CNT_W'(1);
        else if (32'(cfg_wdata) > WINDOW_MAX)
            k_cfg = CNT_W'(WINDOW_MAX);
        else
            k_cfg = CNT_W'(cfg_wdata);
    end

    // window state and search flags
    assign full   = (fill_reg == k_reg);
    assign j_zero = (j_reg == '0);
    assign j_last = ((CNT_W'(j_reg) + CNT_W'(1)) == fill_reg);
    assign at_end = dir_up_reg ? j_last : j_zero;
    assign hit    = (sort_rd == old_reg) || j_last;
    assign move   = dir_up_reg ? (sort_rd < s_reg) : (s_reg < sort_rd);
    assign j_step = dir_up_reg ? (j_reg + IDX_W'(1)) : (j_reg - IDX_W'(1));

    // oldest slot advances and wraps at the window size
    assign pos_plus = (CNT_W + 1)'(pos_reg) + (CNT_W + 1)'(1);
    assign pos_next = (pos_plus >= {1'b0, k_reg}) ? '0 : IDX_W'(pos_plus);

    // lower median rank, ceil(k/2)-1
    assign rank = IDX_W'((k_reg - CNT_W'(1)) >> 1);

    assign status.full      = full;
    assign status.fill_zero = (fill_reg == '0);
    assign status.hit       = hit;
    assign status.move      = move;
    assign status.at_end    = at_end;

    // ring port: read the oldest slot while the new word goes in
    assign ring_we    = (cmd.op == swm_pkg::OP_PREP);
    assign ring_waddr = full ? pos_reg : IDX_W'(fill_reg);

    // sorted store port: shifted words and the final placement go to the hole
    assign sort_we    = (cmd.op == swm_pkg::OP_SHIFT_CMP) || (cmd.op == swm_pkg::OP_FINAL);
    assign sort_wdata = ((cmd.op == swm_pkg::OP_SHIFT_CMP) && move) ? sort_rdata : s_reg;
    assign sort_raddr = ((cmd.op == swm_pkg::OP_MED_RD) || (cmd.op == swm_pkg::OP_MED_OUT))
                        ? rank : j_reg;

    swm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (s_reg),
        .raddr (pos_reg),
        .rdata (ring_rdata)
    );

    swm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_sorted (
        .clk   (clk),
        .we    (sort_we),
        .waddr (hole_reg),
        .wdata (sort_wdata),
        .raddr (sort_raddr),
        .rdata (sort_rdata)
    );

    // window size, fill count and oldest slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= CNT_W'(1);
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                swm_pkg::OP_LOAD:
                begin
                    if (in_start)
                    begin
                        fill_reg <= '0;
                        pos_reg  <= '0;
                    end
                end
                swm_pkg::OP_PREP:
                begin
                    if (full)
                        pos_reg <= pos_next;
                    else
                        fill_reg <= fill_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
            // a register write restarts the stream at the new size
            if (cfg_we)
            begin
                k_reg    <= k_cfg;
                fill_reg <= '0;
                pos_reg  <= '0;
            end
        end
    end

    // sample, search pointers and output word
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            swm_pkg::OP_LOAD:
            begin
                s_reg <= in_sample;
            end
            swm_pkg::OP_PREP:
            begin
                if (full)
                begin
                    j_reg <= '0;
                end
                else
                begin
                    // not full: open a hole at the top and shift down
                    hole_reg   <= IDX_W'(fill_reg);
                    dir_up_reg <= 1'b0;
                    j_reg      <= IDX_W'(fill_reg - CNT_W'(1));
                end
            end
            swm_pkg::OP_OLD:
            begin
                old_reg    <= ring_rd;
                dir_up_reg <= !(s_reg < ring_rd);
            end
            swm_pkg::OP_FIND_CMP:
            begin
                if (hit)
                begin
                    hole_reg <= j_reg;
                    if (!at_end)
                        j_reg <= j_step;
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
            swm_pkg::OP_SHIFT_CMP:
            begin
                if (move)
                begin
                    hole_reg <= j_reg;
                    if (!at_end)
                        j_reg <= j_step;
                end
            end
            default:
            begin
            end
        endcase
        if (cmd.med_load)
        begin
            median_reg <= sort_rd;
        end
    end
endmodule

// File: rtl/swm_checker.sv
// port level checks for the median filter and the bind that attaches them
// depends on sliding_window_median for the bind target
module swm_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] median
);
    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median))
        else $error("stalled median word changed");

    // an accepted sample keeps the input closed through ST_PREP and the state after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input reopened too early after a sample");

    // a new result only appears at the end of an item's processing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the input was open");

    // no result word during reset
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");
endmodule

bind sliding_window_median swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .median    (out_ch.median)
);
